@@ src/box_region_store_core_defines.svh @@
// assertion macros for the box region store
`ifndef BOX_REGION_STORE_CORE_DEFINES_SVH
`define BOX_REGION_STORE_CORE_DEFINES_SVH
// concurrent check on aclk, off during reset
`define BRS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// check in the cycle after a trigger, off during reset
`define BRS_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (prop)) \
        else $error(msg);
`endif

@@ src/brs_pkg.sv @@
// shared types and constants for the box region store
package brs_pkg;
    localparam int DEF_TABLE_DEPTH = 64;
    localparam int MAX_RESULTS     = 64;
    localparam logic [31:0] ALLOC_ID = 32'hFFFF_FFFF;

    localparam logic [2:0] MODE_INSERT  = 3'd0;
    localparam logic [2:0] MODE_REMOVE  = 3'd1;
    localparam logic [2:0] MODE_POINT   = 3'd2;
    localparam logic [2:0] MODE_OVERLAP = 3'd3;
    localparam logic [2:0] MODE_CONTAIN = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_IN_USE   = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOMATCH  = 3'd4;

    typedef struct packed {
        logic [31:0]        id;
        logic signed [15:0] lx, ly, lz, hx, hy, hz;
    } box_t;

    // per-cycle command broadcast from the sequencer to every cell
    typedef struct packed {
        logic        shift;    // rotate the ring one place
        logic        append;   // write new entry into cell at count
        logic        del;      // compact: cells at/after pos take neighbour
        logic [2:0]  mode;
    } cell_ctl_t;
endpackage

@@ src/brs_cell.sv @@
// one storage cell of the ring: holds one box and tests it against the query
module brs_cell (
    input  logic                aclk,
    input  brs_pkg::cell_ctl_t  ctl,
    input  logic                we,
    input  brs_pkg::box_t       wr_box,
    input  brs_pkg::box_t       nb_box,
    input  logic                take_nb,
    input  brs_pkg::box_t       q_box,
    input  logic signed [15:0]  px, py, pz,
    output brs_pkg::box_t       box_out,
    output logic                hit
);
    brs_pkg::box_t box_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            box_reg <= wr_box;
        end else if (take_nb) begin
            box_reg <= nb_box;
        end
    end

    assign box_out = box_reg;

    logic hp, ho, hc;
    always_comb begin
        hp = (box_reg.lx <= px) && (px <= box_reg.hx) && (box_reg.ly <= py) &&
             (py <= box_reg.hy) && (box_reg.lz <= pz) && (pz <= box_reg.hz);
        ho = !((q_box.lx > box_reg.hx) || (q_box.hx < box_reg.lx) ||
               (q_box.ly > box_reg.hy) || (q_box.hy < box_reg.ly) ||
               (q_box.lz > box_reg.hz) || (q_box.hz < box_reg.lz));
        hc = (q_box.lx <= box_reg.lx) && (box_reg.hx <= q_box.hx) &&
             (q_box.ly <= box_reg.ly) && (box_reg.hy <= q_box.hy) &&
             (q_box.lz <= box_reg.lz) && (box_reg.hz <= q_box.hz);
        case (ctl.mode)
            brs_pkg::MODE_POINT:   hit = hp;
            brs_pkg::MODE_OVERLAP: hit = ho;
            brs_pkg::MODE_CONTAIN: hit = hc;
            default:               hit = 1'b0;
        endcase
    end
endmodule

@@ src/box_region_store_core.sv @@
// top level of the box region store: sequencer over a ring of cells
//
// usage: one input item per command on the s_ channel (valid/ready), result
// items on the m_ channel (valid/ready). an item is a mode plus id, region
// corners and a point. insert and remove answer with one item, last set.
// queries answer with one item per matching box in insertion order, up to
// MAX_RESULTS, the final one carrying last; no match gives one no_match item.
// operation: the stored boxes sit in a ring of TABLE_DEPTH cells that
// rotates one place a cycle when not stalled; the head cell is tested each
// cycle. a command is accepted, the ring makes one full rotation and a
// decide step follows; s_ready is high only in idle, so no new item is
// taken before the last one is done. the ring also holds while a match
// waits on a stalled receiver. an allocating insert adds one rotation plus
// decide step per candidate id in use (at most count). remove compacts in
// an extra S_DEL step. unknown modes give no item.
// reset: aresetn clears the entry count and the sequencer; box contents
// are left as they were and are never read beyond the count.
// stall: a result waits in the output register; the ring stops until it
// is taken, so no item is lost or repeated.
`include "box_region_store_core_defines.svh"
module box_region_store_core #(
    parameter int TABLE_DEPTH = brs_pkg::DEF_TABLE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_mode,
    input  logic [31:0]         s_area_id,
    input  logic signed [15:0]  s_min_x, s_min_y, s_min_z,
    input  logic signed [15:0]  s_max_x, s_max_y, s_max_z,
    input  logic signed [15:0]  s_point_x, s_point_y, s_point_z,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_status,
    output logic [31:0]         m_result_id,
    output logic                m_last
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int RW = $clog2(brs_pkg::MAX_RESULTS + 1);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_DEL} state_t;
    state_t state_reg;

    // command latched at accept
    logic [2:0]          mode_reg;
    logic [31:0]         id_reg;
    brs_pkg::box_t       q_reg;        // id field bit 0 flags an allocating insert
    logic signed [15:0]  px_reg, py_reg, pz_reg;
    logic [CW-1:0]       count_reg;
    logic [AW:0]         step_reg;     // rotation progress
    logic                found_reg;
    logic [AW-1:0]       pos_reg;
    logic [RW-1:0]       nres_reg;
    // one pending match held back so that last can be set on the final one
    logic                pend_reg;
    logic [31:0]         pend_id_reg;

    // output register
    logic                ov_reg;
    logic [2:0]          os_reg;
    logic [31:0]         oid_reg;
    logic                ol_reg;

    brs_pkg::box_t  box   [TABLE_DEPTH];
    logic           hit   [TABLE_DEPTH];
    brs_pkg::cell_ctl_t ctl;

    wire out_free = !ov_reg || m_ready;
    // head cell is cell 0; rotating moves cell i+1 into cell i
    wire head_valid = (step_reg < (AW+1)'(count_reg));
    wire head_hit   = head_valid && hit[0];
    wire head_idm   = head_valid && (box[0].id == id_reg);
    wire is_query   = (mode_reg == brs_pkg::MODE_POINT) ||
                      (mode_reg == brs_pkg::MODE_OVERLAP) ||
                      (mode_reg == brs_pkg::MODE_CONTAIN);
    // a query emits a match only when the output can take the previous one
    wire need_out   = is_query && head_hit && pend_reg;
    wire scan_go    = (state_reg == S_SCAN) && (!need_out || out_free);
    wire cap_hit    = (nres_reg == RW'(brs_pkg::MAX_RESULTS));

    always_comb begin
        ctl        = '0;
        ctl.mode   = mode_reg;
        ctl.shift  = scan_go;
        ctl.append = (state_reg == S_DECIDE) && (mode_reg == brs_pkg::MODE_INSERT) &&
                     !found_reg && (count_reg < CW'(TABLE_DEPTH));
        ctl.del    = (state_reg == S_DEL);
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            localparam int NB = (g + 1) % TABLE_DEPTH;
            logic we_c, take_c;
            always_comb begin
                we_c   = ctl.append && (count_reg[AW-1:0] == AW'(g)) &&
                         (count_reg < CW'(TABLE_DEPTH));
                take_c = ctl.shift ||
                         (ctl.del && (AW'(g) >= pos_reg) && (g < TABLE_DEPTH - 1));
            end
            brs_cell u_cell (
                .aclk    (aclk),
                .ctl     (ctl),
                .we      (we_c),
                .wr_box  ({id_reg, q_reg.lx, q_reg.ly, q_reg.lz,
                           q_reg.hx, q_reg.hy, q_reg.hz}),
                .nb_box  (box[NB]),
                .take_nb (take_c),
                .q_box   (q_reg),
                .px      (px_reg),
                .py      (py_reg),
                .pz      (pz_reg),
                .box_out (box[g]),
                .hit     (hit[g])
            );
        end
    endgenerate

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = ov_reg;
    assign m_status    = os_reg;
    assign m_result_id = oid_reg;
    assign m_last      = ol_reg;

    wire scan_done = (step_reg == (AW+1)'(TABLE_DEPTH - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
            pend_reg  <= 1'b0;
            nres_reg  <= '0;
        end else begin
            if (ov_reg && m_ready) ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        mode_reg  <= s_mode;
                        id_reg    <= (s_mode == brs_pkg::MODE_INSERT &&
                                      s_area_id == brs_pkg::ALLOC_ID) ? 32'd0 : s_area_id;
                        q_reg     <= {31'd0, (s_mode == brs_pkg::MODE_INSERT &&
                                              s_area_id == brs_pkg::ALLOC_ID),
                                      s_min_x, s_min_y, s_min_z,
                                      s_max_x, s_max_y, s_max_z};
                        px_reg    <= s_point_x;
                        py_reg    <= s_point_y;
                        pz_reg    <= s_point_z;
                        step_reg  <= '0;
                        found_reg <= 1'b0;
                        nres_reg  <= '0;
                        pend_reg  <= 1'b0;
                        if (s_mode <= brs_pkg::MODE_CONTAIN) state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_go) begin
                        step_reg <= step_reg + 1'b1;
                        if (head_idm && !found_reg) begin
                            found_reg <= 1'b1;
                            pos_reg   <= step_reg[AW-1:0];
                        end
                        if (is_query && head_hit && !cap_hit) begin
                            nres_reg    <= nres_reg + 1'b1;
                            pend_reg    <= 1'b1;
                            pend_id_reg <= box[0].id;
                            if (pend_reg) begin
                                ov_reg  <= 1'b1;
                                os_reg  <= brs_pkg::ST_OK;
                                oid_reg <= pend_id_reg;
                                ol_reg  <= 1'b0;
                            end
                        end
                        if (scan_done) state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                        ov_reg    <= 1'b1;
                        ol_reg    <= 1'b1;
                        oid_reg   <= id_reg;
                        case (mode_reg)
                            brs_pkg::MODE_INSERT: begin
                                if (found_reg && q_reg.id[0]) begin
                                    // allocating: candidate in use, try next
                                    ov_reg    <= 1'b0;
                                    id_reg    <= id_reg + 32'd1;
                                    found_reg <= 1'b0;
                                    step_reg  <= '0;
                                    state_reg <= S_SCAN;
                                end else if (found_reg) begin
                                    os_reg <= brs_pkg::ST_IN_USE;
                                end else if (count_reg >= CW'(TABLE_DEPTH)) begin
                                    os_reg <= brs_pkg::ST_FULL;
                                end else begin
                                    os_reg    <= brs_pkg::ST_OK;
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            brs_pkg::MODE_REMOVE: begin
                                if (found_reg) begin
                                    ov_reg    <= 1'b0;
                                    state_reg <= S_DEL;
                                end else begin
                                    os_reg <= brs_pkg::ST_NOTFOUND;
                                end
                            end
                            default: begin
                                if (pend_reg) begin
                                    os_reg  <= brs_pkg::ST_OK;
                                    oid_reg <= pend_id_reg;
                                end else begin
                                    os_reg  <= brs_pkg::ST_NOMATCH;
                                    oid_reg <= 32'd0;
                                end
                                pend_reg <= 1'b0;
                            end
                        endcase
                    end
                end
                S_DEL: begin
                    count_reg <= count_reg - 1'b1;
                    ov_reg    <= 1'b1;
                    os_reg    <= brs_pkg::ST_OK;
                    oid_reg   <= id_reg;
                    ol_reg    <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `BRS_ASSERT(a_count_range, count_reg <= CW'(TABLE_DEPTH), "entry count beyond depth")
    `BRS_ASSERT(a_no_accept_busy, (state_reg != S_IDLE) |-> !s_ready, "ready while busy")
    `BRS_ASSERT_NEXT(a_del_shrinks, state_reg == S_DEL,
                     count_reg == $past(count_reg) - 1'b1, "remove did not shrink table")
    `BRS_ASSERT(a_res_cap, nres_reg <= RW'(brs_pkg::MAX_RESULTS), "result count over limit")
endmodule
